### design/twmc_pkg.sv
// Package for the trim wheel motion controller: phase and motion codes,
// register map, controller states and the controller/datapath command types.
// No dependencies.
package twmc_pkg;

    localparam int POSITION_BITS_DEF    = 24;
    localparam int TRIM_FRAC_BITS       = 15;
    localparam int POWER_TIMEOUT_MS_DEF = 0;
    localparam int CALIB_RATE_DEF       = 400;

    localparam int TRIM_BITS = TRIM_FRAC_BITS + 1;
    localparam int DIV_BITS  = 48;

    typedef enum logic [2:0] {
        PH_WAIT     = 3'd0,
        PH_SEEK_CW  = 3'd1,
        PH_SEEK_CCW = 3'd2,
        PH_CENTRING = 3'd3,
        PH_FOLLOW   = 3'd4,
        PH_FAULT    = 3'd5
    } phase_t;

    localparam logic [1:0] MOT_NONE = 2'd0;
    localparam logic [1:0] MOT_STOP = 2'd1;
    localparam logic [1:0] MOT_CW   = 2'd2;
    localparam logic [1:0] MOT_CCW  = 2'd3;

    localparam logic [2:0] REG_CALIB_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_POS_DEADBAND  = 3'd1;
    localparam logic [2:0] REG_DRIVE_GAIN    = 3'd2;
    localparam logic [2:0] REG_MIN_SPEED     = 3'd3;
    localparam logic [2:0] REG_MAX_SPEED     = 3'd4;
    localparam logic [2:0] REG_BACKOFF       = 3'd5;
    localparam logic [2:0] REG_MANUAL_MOVE   = 3'd6;
    localparam logic [2:0] REG_FOLLOW_DB     = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } ctl_state_t;

    typedef struct packed {
        logic start;
        logic div_go;
        logic finish;
    } twmc_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } twmc_sts_t;

endpackage

### design/twmc_ctrl.sv
// Controller: sequences one control tick through compute, optional divide
// and commit. Depends on twmc_pkg.
module twmc_ctrl
    import twmc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    output logic      m_axis_tvalid,
    input  logic      m_axis_tready,
    output twmc_cmd_t cmd,
    input  twmc_sts_t sts
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (sts.need_div) begin
                    cmd.div_go = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### design/twmc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on twmc_pkg.
module twmc_div
    import twmc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                go,
    input  logic [DIV_BITS-1:0] num,
    input  logic [DIV_BITS-1:0] den,
    output logic [DIV_BITS-1:0] quo,
    output logic                done
);

    localparam int CNT_BITS = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0] quo_reg, quo_next;
    logic [DIV_BITS-1:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [DIV_BITS:0]   trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[DIV_BITS-1]};
        if (go) begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(DIV_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                trial = trial - {1'b0, den_reg};
                quo_next = {quo_reg[DIV_BITS-2:0], 1'b1};
            end else begin
                quo_next = {quo_reg[DIV_BITS-2:0], 1'b0};
            end
            rem_next = trial[DIV_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (go) begin
            den_reg <= den;
        end
    end

    assign quo  = quo_reg;
    assign done = busy_reg && (cnt_reg == CNT_BITS'(1));

endmodule

### design/twmc_dp.sv
// Datapath: configuration registers, controller state, tick arithmetic and
// result register. Depends on twmc_pkg and twmc_div.
module twmc_dp
    import twmc_pkg::*;
#(
    parameter int POSITION_BITS    = POSITION_BITS_DEF,
    parameter int POWER_TIMEOUT_MS = POWER_TIMEOUT_MS_DEF,
    parameter int CALIB_RATE       = CALIB_RATE_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  twmc_cmd_t                cmd,
    output twmc_sts_t                sts,
    input  logic [31:0]              in_now,
    input  logic                     in_pg,
    input  logic                     in_cwl,
    input  logic                     in_ccwl,
    input  logic [POSITION_BITS-1:0] in_pos,
    input  logic                     in_center,
    input  logic                     in_recal,
    input  logic                     in_trim_new,
    input  logic [TRIM_BITS-1:0]     in_trim,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_idx,
    input  logic [31:0]              cfg_wdata,
    output logic [31:0]              cfg_rdata,
    output logic [47:0]              result
);

    localparam int PB = POSITION_BITS;
    localparam int WB = PB + 2;
    localparam int MB = WB + TRIM_FRAC_BITS + 2;
    localparam logic signed [MB-1:0] T_ONE = MB'(1) <<< TRIM_FRAC_BITS;
    localparam logic signed [MB-1:0] T_HALF = MB'(1) <<< (TRIM_FRAC_BITS - 1);
    localparam logic signed [WB-1:0] P_MIN = -(WB'(1) <<< (PB - 1));
    localparam logic signed [WB-1:0] P_MAX = (WB'(1) <<< (PB - 1)) - WB'(1);
    localparam logic signed [17:0]   Q_ONE = 18'sd32768;

    // configuration
    logic [15:0] calib_to_reg, gain_reg, min_spd_reg, max_spd_reg, backoff_reg;
    logic [9:0]  pos_db_reg, manual_reg;
    logic [14:0] follow_db_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_to_reg  <= 16'd20000;
            pos_db_reg    <= 10'd4;
            gain_reg      <= 16'd256;
            min_spd_reg   <= 16'd50;
            max_spd_reg   <= 16'd2000;
            backoff_reg   <= 16'd200;
            manual_reg    <= 10'd8;
            follow_db_reg <= 15'd33;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_CALIB_TIMEOUT: calib_to_reg  <= cfg_wdata[15:0];
                REG_POS_DEADBAND:  pos_db_reg    <= cfg_wdata[9:0];
                REG_DRIVE_GAIN:    gain_reg      <= cfg_wdata[15:0];
                REG_MIN_SPEED:     min_spd_reg   <= cfg_wdata[15:0];
                REG_MAX_SPEED:     max_spd_reg   <= cfg_wdata[15:0];
                REG_BACKOFF:       backoff_reg   <= cfg_wdata[15:0];
                REG_MANUAL_MOVE:   manual_reg    <= cfg_wdata[9:0];
                REG_FOLLOW_DB:     follow_db_reg <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_CALIB_TIMEOUT: cfg_rdata = {16'd0, calib_to_reg};
            REG_POS_DEADBAND:  cfg_rdata = {22'd0, pos_db_reg};
            REG_DRIVE_GAIN:    cfg_rdata = {16'd0, gain_reg};
            REG_MIN_SPEED:     cfg_rdata = {16'd0, min_spd_reg};
            REG_MAX_SPEED:     cfg_rdata = {16'd0, max_spd_reg};
            REG_BACKOFF:       cfg_rdata = {16'd0, backoff_reg};
            REG_MANUAL_MOVE:   cfg_rdata = {22'd0, manual_reg};
            REG_FOLLOW_DB:     cfg_rdata = {17'd0, follow_db_reg};
            default:           cfg_rdata = '0;
        endcase
    end

    // latched beat
    logic [31:0] now_reg;
    logic        pg_reg, cwl_reg, ccwl_reg, center_reg, recal_reg, tnew_reg;
    logic signed [PB-1:0] pos_reg;
    logic signed [15:0]   tin_reg;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            now_reg    <= in_now;
            pg_reg     <= in_pg;
            cwl_reg    <= in_cwl;
            ccwl_reg   <= in_ccwl;
            pos_reg    <= in_pos;
            center_reg <= in_center;
            recal_reg  <= in_recal;
            tnew_reg   <= in_trim_new;
            tin_reg    <= in_trim;
        end
    end

    // controller state
    logic [2:0]  phase_reg, phase_next;
    logic [31:0] pstart_reg, pstart_next;
    logic signed [PB-1:0] cwp_reg, cwp_next, ccwp_reg, ccwp_next, cen_reg, cen_next;
    logic signed [PB-1:0] bgoal_reg, bgoal_next, fwb_reg, fwb_next;
    logic drv_reg, drv_next, ctr_reg, ctr_next, bk_reg, bk_next, coil_reg, coil_next;
    logic signed [15:0] rtrim_reg, rtrim_next, ltrim_reg, ltrim_next;

    // stage 1 (ST_CALC): trim-to-position target and pos-to-trim setup
    logic signed [15:0] lt_eff;
    logic signed [MB-1:0] s_cl, tp_mul, tp_mag, tp_q;
    logic signed [WB-1:0] tgt_trim, tgt_reg;
    logic signed [WB-1:0] span, dd, cc;
    logic [WB-1:0] ud, uc;
    logic          p2t_lo, p2t_zero, p2t_cz;
    logic [DIV_BITS-1:0] dnum, dden;
    logic signed [WB-1:0] tgt_reg_n;
    logic          lo_reg, zero_reg, cz_reg;

    assign lt_eff = (phase_reg == 3'(PH_FOLLOW) && tnew_reg) ? tin_reg : ltrim_reg;

    always_comb begin
        s_cl = MB'(lt_eff);
        if (s_cl > T_ONE - 1) s_cl = T_ONE - 1;
        if (s_cl < -T_ONE) s_cl = -T_ONE;
        if (s_cl <= 0) tp_mul = (s_cl + T_ONE) * MB'(WB'(cen_reg) - WB'(cwp_reg));
        else           tp_mul = s_cl * MB'(WB'(ccwp_reg) - WB'(cen_reg));
        tp_mag = (tp_mul < 0) ? -tp_mul : tp_mul;
        tp_q   = (tp_mag + T_HALF) >>> TRIM_FRAC_BITS;
        if (tp_mul < 0) tp_q = -tp_q;
        tgt_trim = (s_cl <= 0) ? WB'(cwp_reg) + WB'(tp_q) : WB'(cen_reg) + WB'(tp_q);

        span = WB'(ccwp_reg) - WB'(cwp_reg);
        dd   = WB'(pos_reg) - WB'(cwp_reg);
        cc   = WB'(cen_reg) - WB'(cwp_reg);
        if (span < 0) begin
            span = -span;
            dd   = -dd;
            cc   = -cc;
        end
        if (dd < 0) dd = '0;
        if (dd > span) dd = span;
        if (cc < 0) cc = '0;
        if (cc > span) cc = span;
        ud = dd;
        uc = cc;
        p2t_zero = (span == 0);
        p2t_lo   = (ud <= uc);
        p2t_cz   = (uc == 0);
        if (p2t_lo) begin
            dnum = (DIV_BITS'(ud) << TRIM_FRAC_BITS) + DIV_BITS'(uc >> 1);
            dden = DIV_BITS'(uc);
        end else begin
            dnum = (DIV_BITS'(ud - uc) << TRIM_FRAC_BITS)
                 + DIV_BITS'((WB'(span) - uc) >> 1);
            dden = DIV_BITS'(WB'(span) - uc);
        end
        tgt_reg_n = tgt_trim;
    end

    logic manual_move;
    logic signed [WB-1:0] fw_diff;
    assign fw_diff = WB'(pos_reg) - WB'(fwb_reg);
    assign manual_move = ((fw_diff < 0) ? -fw_diff : fw_diff) > WB'(manual_reg);

    logic trim_far;
    logic signed [16:0] tdiff;
    assign tdiff = 17'(tin_reg) - 17'(rtrim_reg);
    assign trim_far = ((tdiff < 0) ? -tdiff : tdiff) > 17'(follow_db_reg);

    // divide only when the follow tick will reach the manual report
    assign sts.need_div = (phase_reg == 3'(PH_FOLLOW)) && !recal_reg && !center_reg
                        && !drv_reg && !bk_reg && !cwl_reg && !ccwl_reg && manual_move
                        && !(tnew_reg && !ctr_reg && trim_far) && !p2t_zero
                        && !(p2t_lo && p2t_cz);

    logic [DIV_BITS-1:0] quo;
    twmc_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .go     (cmd.div_go),
        .num    (dnum),
        .den    (dden),
        .quo    (quo),
        .done   (sts.div_done)
    );

    always_ff @(posedge aclk) begin
        lo_reg   <= p2t_lo;
        zero_reg <= p2t_zero;
        cz_reg   <= p2t_cz;
        tgt_reg  <= tgt_reg_n;
    end

    // pos-to-trim result
    logic signed [15:0] p2t;
    logic [DIV_BITS-1:0] qsat;
    always_comb begin
        qsat = (quo > DIV_BITS'(Q_ONE)) ? DIV_BITS'(Q_ONE) : quo;
        if (zero_reg)            p2t = '0;
        else if (lo_reg && cz_reg) p2t = 16'sh8000;
        else if (lo_reg)         p2t = 16'(18'(qsat) - Q_ONE);
        else if (qsat >= DIV_BITS'(Q_ONE)) p2t = 16'sh7FFF;
        else                     p2t = 16'(qsat);
    end

    // drive helper
    function automatic logic [17:0] drive(input logic signed [WB-1:0] err);
        logic [WB-1:0] a;
        logic [WB+15:0] prod;
        logic [WB+7:0]  spd;
        logic [15:0]    rate;
        logic           ccw;
        a    = (err < 0) ? WB'(-err) : WB'(err);
        prod = (WB+16)'(a) * (WB+16)'(gain_reg);
        spd  = prod[WB+15:8];
        if (spd < (WB+8)'(min_spd_reg))      rate = min_spd_reg;
        else if (spd > (WB+8)'(max_spd_reg)) rate = max_spd_reg;
        else                                 rate = spd[15:0];
        ccw = ((err > 0) == (ccwp_reg > cwp_reg));
        if (a <= WB'(pos_db_reg)) return {MOT_STOP, 16'd0};
        return {ccw ? MOT_CCW : MOT_CW, rate};
    endfunction

    logic [1:0]  o_mot;
    logic [15:0] o_rate;
    logic        o_zero, o_send;
    logic signed [15:0] o_trim;
    logic [17:0] dres;
    logic signed [WB-1:0] step, goal;
    logic        timed;

    always_comb begin
        phase_next  = phase_reg;
        pstart_next = pstart_reg;
        cwp_next    = cwp_reg;
        ccwp_next   = ccwp_reg;
        cen_next    = cen_reg;
        bgoal_next  = bgoal_reg;
        fwb_next    = fwb_reg;
        drv_next    = drv_reg;
        ctr_next    = ctr_reg;
        bk_next     = bk_reg;
        coil_next   = coil_reg;
        rtrim_next  = rtrim_reg;
        ltrim_next  = ltrim_reg;
        o_mot  = MOT_NONE;
        o_rate = '0;
        o_zero = 1'b0;
        o_send = 1'b0;
        o_trim = '0;
        dres   = '0;
        step   = '0;
        goal   = '0;
        timed  = (now_reg - pstart_reg) > 32'(calib_to_reg);
        case (phase_reg)
            3'(PH_WAIT): begin
                if (pg_reg) begin
                    drv_next = 1'b0; ctr_next = 1'b0; o_zero = 1'b1; coil_next = 1'b1;
                    phase_next = 3'(PH_SEEK_CW); pstart_next = now_reg;
                end else if (POWER_TIMEOUT_MS != 0
                             && (now_reg - pstart_reg) > 32'(POWER_TIMEOUT_MS)) begin
                    phase_next = 3'(PH_FAULT); pstart_next = now_reg;
                end
            end
            3'(PH_SEEK_CW): begin
                if (cwl_reg) begin
                    o_mot = MOT_STOP; cwp_next = pos_reg;
                    phase_next = 3'(PH_SEEK_CCW); pstart_next = now_reg;
                end else if (timed) begin
                    phase_next = 3'(PH_FAULT); pstart_next = now_reg;
                end else begin
                    o_mot = MOT_CW; o_rate = 16'(CALIB_RATE);
                end
            end
            3'(PH_SEEK_CCW): begin
                if (ccwl_reg) begin
                    o_mot = MOT_STOP; ccwp_next = pos_reg;
                    step = WB'(pos_reg) - WB'(cwp_reg);
                    step = (step < 0) ? -((-step) >>> 1) : (step >>> 1);
                    cen_next = PB'(WB'(cwp_reg) + step);
                    phase_next = 3'(PH_CENTRING); pstart_next = now_reg;
                end else if (timed) begin
                    phase_next = 3'(PH_FAULT); pstart_next = now_reg;
                end else begin
                    o_mot = MOT_CCW; o_rate = 16'(CALIB_RATE);
                end
            end
            3'(PH_CENTRING): begin
                dres = drive(WB'(cen_reg) - WB'(pos_reg));
                o_mot = dres[17:16]; o_rate = dres[15:0];
                if (dres[17:16] == MOT_STOP) begin
                    rtrim_next = '0; coil_next = 1'b0; bk_next = 1'b0; fwb_next = pos_reg;
                    phase_next = 3'(PH_FOLLOW); pstart_next = now_reg;
                end else if (timed) begin
                    phase_next = 3'(PH_FAULT); pstart_next = now_reg;
                end
            end
            3'(PH_FOLLOW): begin
                if (recal_reg) begin
                    drv_next = 1'b0; ctr_next = 1'b0; o_zero = 1'b1; coil_next = 1'b1;
                    phase_next = 3'(PH_SEEK_CW); pstart_next = now_reg;
                end else begin
                    if (center_reg) begin
                        coil_next = 1'b1; drv_next = 1'b1; ctr_next = 1'b1;
                    end
                    if (tnew_reg) begin
                        ltrim_next = tin_reg;
                        if (!ctr_next && trim_far) begin
                            coil_next = 1'b1; drv_next = 1'b1;
                        end
                    end
                    if (drv_next) begin
                        dres = drive((ctr_next ? WB'(cen_reg) : tgt_reg) - WB'(pos_reg));
                        o_mot = dres[17:16]; o_rate = dres[15:0];
                        if (dres[17:16] == MOT_STOP) begin
                            drv_next = 1'b0;
                            if (ctr_next) begin
                                o_send = 1'b1; rtrim_next = '0; ctr_next = 1'b0;
                            end else begin
                                rtrim_next = ltrim_next;
                            end
                            coil_next = 1'b0; bk_next = 1'b0; fwb_next = pos_reg;
                        end
                    end else if (bk_reg) begin
                        dres = drive(WB'(bgoal_reg) - WB'(pos_reg));
                        o_mot = dres[17:16]; o_rate = dres[15:0];
                        if (dres[17:16] == MOT_STOP) begin
                            bk_next = 1'b0; coil_next = 1'b0; fwb_next = pos_reg;
                        end
                    end else if (cwl_reg || ccwl_reg) begin
                        step = WB'(backoff_reg);
                        if (ccwp_reg < cwp_reg) step = -step;
                        if (!cwl_reg) step = -step;
                        goal = WB'(pos_reg) + step;
                        if (goal < P_MIN) goal = P_MIN;
                        if (goal > P_MAX) goal = P_MAX;
                        bgoal_next = PB'(goal);
                        coil_next = 1'b1; bk_next = 1'b1;
                    end else if (manual_move) begin
                        o_send = 1'b1; o_trim = p2t; rtrim_next = p2t; fwb_next = pos_reg;
                    end
                end
            end
            default: coil_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= 3'(PH_WAIT);
            pstart_reg <= '0;
            cwp_reg    <= '0;
            ccwp_reg   <= '0;
            cen_reg    <= '0;
            bgoal_reg  <= '0;
            fwb_reg    <= '0;
            drv_reg    <= 1'b0;
            ctr_reg    <= 1'b0;
            bk_reg     <= 1'b0;
            coil_reg   <= 1'b0;
            rtrim_reg  <= '0;
            ltrim_reg  <= '0;
        end else if (cmd.finish) begin
            phase_reg  <= phase_next;
            pstart_reg <= pstart_next;
            cwp_reg    <= cwp_next;
            ccwp_reg   <= ccwp_next;
            cen_reg    <= cen_next;
            bgoal_reg  <= bgoal_next;
            fwb_reg    <= fwb_next;
            drv_reg    <= drv_next;
            ctr_reg    <= ctr_next;
            bk_reg     <= bk_next;
            coil_reg   <= coil_next;
            rtrim_reg  <= rtrim_next;
            ltrim_reg  <= ltrim_next;
        end
    end

    logic [47:0] result_reg;
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            result_reg <= {6'd0,
                           !pg_reg ? 2'd0 : (phase_next == 3'(PH_FOLLOW) ? 2'd1 : 2'd2),
                           o_trim, o_send, o_zero, o_rate, o_mot, coil_next, phase_next};
        end
    end
    assign result = result_reg;

endmodule

### design/trim_wheel_motion_controller_top.sv
// Channel     Dir  Beat contents
// s_axis      in   control tick: time, switches, position, buttons, trim
// m_axis      out  drive command, trim report, mode
// apb         in   eight configuration registers at 4*i
// A tick passes ST_IDLE, ST_CALC, ST_FINISH and ST_OUT, with ST_DIV before ST_FINISH
// when a manual turn is converted to trim (48 steps of the serial divider). One tick at
// a time; the next beat is taken once the result has been taken. Reset is synchronous,
// active low. Depends on twmc_pkg, twmc_ctrl, twmc_dp.
module trim_wheel_motion_controller_top
    import twmc_pkg::*;
#(
    parameter int POSITION_BITS    = POSITION_BITS_DEF,
    parameter int POWER_TIMEOUT_MS = POWER_TIMEOUT_MS_DEF,
    parameter int CALIB_RATE       = CALIB_RATE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // now_ms[31:0], power_good, cw_limit, ccw_limit, position, center_press,
    // recal_press, trim_new, trim_value, zero fill
    input  logic [((POSITION_BITS + 55 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ctrl_mode[2:0], coil_enable, motion[1:0], step_rate[15:0], sensor_zero,
    // trim_send, trim_out[15:0], led_mode[1:0], zero fill
    output logic [47:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PB = POSITION_BITS;

    twmc_cmd_t cmd;
    twmc_sts_t sts;

    assign pready = 1'b1;

    twmc_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cmd          (cmd),
        .sts          (sts)
    );

    twmc_dp #(
        .POSITION_BITS   (POSITION_BITS),
        .POWER_TIMEOUT_MS(POWER_TIMEOUT_MS),
        .CALIB_RATE      (CALIB_RATE)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_now     (s_axis_tdata[31:0]),
        .in_pg      (s_axis_tdata[32]),
        .in_cwl     (s_axis_tdata[33]),
        .in_ccwl    (s_axis_tdata[34]),
        .in_pos     (s_axis_tdata[35 +: PB]),
        .in_center  (s_axis_tdata[35 + PB]),
        .in_recal   (s_axis_tdata[36 + PB]),
        .in_trim_new(s_axis_tdata[37 + PB]),
        .in_trim    (s_axis_tdata[38 + PB +: TRIM_BITS]),
        .cfg_we     (psel && penable && pwrite),
        .cfg_idx    (paddr[4:2]),
        .cfg_wdata  (pwdata),
        .cfg_rdata  (prdata),
        .result     (m_axis_tdata)
    );

endmodule

### tb/tb_trim_wheel_motion_controller_top.sv
// Self-checking testbench for trim_wheel_motion_controller_top: streams control ticks, predicts
// every result beat with an in-bench controller model and checks it field by field.
// Depends on twmc_pkg and the design sources.
`timescale 1ns / 100ps

module tb_trim_wheel_motion_controller_top;
    import twmc_pkg::*;

    localparam longint POS_LO = -(64'sd1 <<< 23);
    localparam longint POS_HI = (64'sd1 <<< 23) - 1;
    localparam longint Q_ONE  = 64'sd32768;
    localparam int CAL_RATE   = 400;
    localparam int DRAIN_CYC  = 64;

    localparam int OP_AUTO     = 0;
    localparam int OP_RECAL    = 1;
    localparam int OP_CENTRE   = 2;
    localparam int OP_TRIM_MIN = 3;
    localparam int OP_TRIM_MAX = 4;
    localparam int OP_LIM_CW   = 5;
    localparam int OP_LIM_CCW  = 6;
    localparam int OP_NO_POWER = 7;

    typedef struct {
        bit [31:0] now;
        bit        pg;
        bit        cw;
        bit        ccw;
        bit [23:0] pos;
        bit        cp;
        bit        rc;
        bit        tn;
        bit [15:0] tv;
    } tick_t;

    typedef struct packed {
        bit [5:0]  pad;
        bit [1:0]  led;
        bit [15:0] trim;
        bit        send;
        bit        zero;
        bit [15:0] rate;
        bit [1:0]  mot;
        bit        coil;
        bit [2:0]  mode;
    } drive_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    trim_wheel_motion_controller_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // predictor copy of registers and controller state
    bit [15:0] r_timeout = 20000, r_gain = 256, r_min = 50, r_max = 2000, r_backoff = 200;
    bit [9:0]  r_db = 4, r_manual = 8;
    bit [14:0] r_fdb = 33;
    phase_t    ctl_phase = PH_WAIT;
    bit [31:0] ph_t0;
    longint    lim_cw, lim_ccw, mid, bgoal, fw_base, ref_trim, last_trim;
    bit        drv, ctr, bck, coils;
    bit [1:0]  o_mot;
    longint    o_rate, o_trim;
    bit        o_zero, o_send;
    bit [31:0] t_now;
    longint    t_pos;

    tick_t      tick_q[$];
    drive_cmd_t cmd_q[$];
    int         errors = 0;
    bit         quiet = 1'b0;
    int         src_gap = 0, snk_gap = 0;
    tick_t      drv_tick;
    drive_cmd_t got;

    // stimulus generator state
    bit [31:0] sim_now;
    longint    sim_pos, plan_cw, plan_ccw;

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void goto_phase(phase_t p);
        ctl_phase = p;
        ph_t0 = t_now;
    endfunction

    function automatic bit timed_out();
        bit [31:0] el;
        el = t_now - ph_t0;
        return el > {16'd0, r_timeout};
    endfunction

    function automatic void begin_seek();
        drv = 0;
        ctr = 0;
        o_zero = 1;
        coils = 1;
        goto_phase(PH_SEEK_CW);
    endfunction

    function automatic void freewheel();
        coils = 0;
        bck = 0;
        fw_base = t_pos;
    endfunction

    function automatic bit drive_toward(longint tgt);
        longint err, a, spd;
        err = tgt - t_pos;
        a = absl(err);
        if (a <= r_db) begin
            o_mot = MOT_STOP;
            o_rate = 0;
            return 1;
        end
        spd = (a * r_gain) >>> 8;
        if (spd < r_min) spd = r_min;
        else if (spd > r_max) spd = r_max;
        o_mot = ((err > 0) == (lim_ccw > lim_cw)) ? MOT_CCW : MOT_CW;
        o_rate = spd;
        return 0;
    endfunction

    function automatic longint q15_round(longint num);
        longint q;
        q = (absl(num) + 16384) >>> 15;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint trim_to_counts(longint s);
        if (s < -Q_ONE) s = -Q_ONE;
        if (s > Q_ONE - 1) s = Q_ONE - 1;
        if (s <= 0) return lim_cw + q15_round((s + Q_ONE) * (mid - lim_cw));
        return mid + q15_round(s * (lim_ccw - mid));
    endfunction

    function automatic longint counts_to_trim(longint p);
        longint span, d, c, r;
        span = lim_ccw - lim_cw;
        d = p - lim_cw;
        c = mid - lim_cw;
        if (span == 0) return 0;
        if (span < 0) begin
            span = -span;
            d = -d;
            c = -c;
        end
        if (d < 0) d = 0;
        if (d > span) d = span;
        if (c < 0) c = 0;
        if (c > span) c = span;
        if (d <= c) begin
            if (c == 0) return -Q_ONE;
            r = -Q_ONE + (d * Q_ONE + c / 2) / c;
        end else begin
            r = ((d - c) * Q_ONE + (span - c) / 2) / (span - c);
        end
        if (r > Q_ONE - 1) r = Q_ONE - 1;
        if (r < -Q_ONE) r = -Q_ONE;
        return r;
    endfunction

    function automatic void follow_tick(tick_t it);
        longint stp, g, s;
        if (it.rc) begin
            begin_seek();
            return;
        end
        if (it.cp) begin
            coils = 1;
            drv = 1;
            ctr = 1;
        end
        if (it.tn) begin
            last_trim = longint'($signed(it.tv));
            if (!ctr && absl(last_trim - ref_trim) > r_fdb) begin
                coils = 1;
                drv = 1;
            end
        end
        if (drv) begin
            if (drive_toward(ctr ? mid : trim_to_counts(last_trim))) begin
                drv = 0;
                if (ctr) begin
                    o_send = 1;
                    o_trim = 0;
                    ref_trim = 0;
                    ctr = 0;
                end else begin
                    ref_trim = last_trim;
                end
                freewheel();
            end
            return;
        end
        if (bck) begin
            if (drive_toward(bgoal)) begin
                bck = 0;
                freewheel();
            end
            return;
        end
        if (it.cw || it.ccw) begin
            stp = r_backoff;
            if (lim_ccw < lim_cw) stp = -stp;
            if (!it.cw) stp = -stp;
            g = t_pos + stp;
            if (g < POS_LO) g = POS_LO;
            if (g > POS_HI) g = POS_HI;
            bgoal = g;
            coils = 1;
            bck = 1;
            return;
        end
        if (absl(t_pos - fw_base) > r_manual) begin
            s = counts_to_trim(t_pos);
            o_send = 1;
            o_trim = s;
            ref_trim = s;
            fw_base = t_pos;
        end
    endfunction

    function automatic drive_cmd_t predict_tick(tick_t it);
        drive_cmd_t r;
        longint sp;
        t_now = it.now;
        t_pos = longint'($signed(it.pos));
        o_mot = MOT_NONE;
        o_rate = 0;
        o_zero = 0;
        o_send = 0;
        o_trim = 0;
        case (ctl_phase)
            PH_WAIT: if (it.pg) begin_seek();
            PH_SEEK_CW: begin
                if (it.cw) begin
                    o_mot = MOT_STOP;
                    lim_cw = t_pos;
                    goto_phase(PH_SEEK_CCW);
                end else if (timed_out()) begin
                    goto_phase(PH_FAULT);
                end else begin
                    o_mot = MOT_CW;
                    o_rate = CAL_RATE;
                end
            end
            PH_SEEK_CCW: begin
                if (it.ccw) begin
                    sp = t_pos - lim_cw;
                    o_mot = MOT_STOP;
                    lim_ccw = t_pos;
                    mid = lim_cw + sp / 2;
                    goto_phase(PH_CENTRING);
                end else if (timed_out()) begin
                    goto_phase(PH_FAULT);
                end else begin
                    o_mot = MOT_CCW;
                    o_rate = CAL_RATE;
                end
            end
            PH_CENTRING: begin
                if (drive_toward(mid)) begin
                    ref_trim = 0;
                    freewheel();
                    goto_phase(PH_FOLLOW);
                end else if (timed_out()) begin
                    goto_phase(PH_FAULT);
                end
            end
            PH_FOLLOW: follow_tick(it);
            default: coils = 0;
        endcase
        r = '0;
        r.mode = ctl_phase;
        r.coil = coils;
        r.mot = o_mot;
        r.rate = o_rate[15:0];
        r.zero = o_zero;
        r.send = o_send;
        r.trim = o_trim[15:0];
        r.led = !it.pg ? 2'd0 : (ctl_phase == PH_FOLLOW ? 2'd1 : 2'd2);
        return r;
    endfunction

    task automatic gen_tick(int op);
        tick_t  it;
        longint tgt;
        bit [23:0] rp;
        int     k;
        sim_now += $urandom_range(0, 4);
        it = '{default: 0};
        it.tv = $urandom;
        it.pg = ($urandom % 25) != 0;
        case (ctl_phase)
            PH_WAIT: it.pg = ($urandom % 4) == 0 && op != OP_NO_POWER;
            PH_SEEK_CW: begin
                it.ccw = $urandom;
                if ($urandom % 5 == 0) begin
                    it.cw = 1;
                    sim_pos = plan_cw;
                end else begin
                    sim_pos += (plan_cw - sim_pos) / 4;
                end
            end
            PH_SEEK_CCW: begin
                it.cw = $urandom;
                if ($urandom % 5 == 0) begin
                    it.ccw = 1;
                    sim_pos = plan_ccw;
                end else begin
                    sim_pos += (plan_ccw - sim_pos) / 4;
                end
            end
            PH_CENTRING: sim_pos += (mid - sim_pos) * longint'($urandom_range(1, 4)) / 4;
            PH_FOLLOW: ;
            default: begin
                it.cw = $urandom;
                it.ccw = $urandom;
            end
        endcase
        if (ctl_phase != PH_FOLLOW) begin
            it.cp = $urandom;
            it.rc = $urandom;
            it.tn = $urandom;
        end else begin
            if (drv || bck) begin
                tgt = bck && !drv ? bgoal : (ctr ? mid : trim_to_counts(last_trim));
                sim_pos += (tgt - sim_pos) * longint'($urandom_range(1, 4)) / 4;
            end
            if ($urandom % 6 == 0) sim_pos += longint'($urandom_range(0, 80)) - 40;
            if ($urandom % 40 == 0) begin
                rp = $urandom;
                sim_pos = longint'($signed(rp));
            end
            k = $urandom % 100;
            if (op == OP_RECAL || (op == OP_AUTO && k < 3)) it.rc = 1;
            else if (op == OP_CENTRE || (op == OP_AUTO && k < 9)) it.cp = 1;
            else if (op == OP_TRIM_MIN) begin
                it.tn = 1;
                it.tv = 16'h8000;
            end else if (op == OP_TRIM_MAX) begin
                it.tn = 1;
                it.tv = 16'h7fff;
            end else if (op == OP_AUTO && k < 45) begin
                it.tn = 1;
                if ($urandom % 8 == 0) it.tv = ($urandom % 2) ? 16'h8000 : 16'h7fff;
            end else if (op == OP_LIM_CW || op == OP_LIM_CCW || (op == OP_AUTO && k < 55)) begin
                it.cw = op == OP_LIM_CW || (op == OP_AUTO && $urandom % 3 != 0);
                it.ccw = op == OP_LIM_CCW || (op == OP_AUTO && !it.cw) ||
                         (op == OP_AUTO && $urandom % 4 == 0);
                if ($urandom % 4 == 0) sim_pos = ($urandom % 2) ? POS_HI : POS_LO;
            end
        end
        if (sim_pos < POS_LO) sim_pos = POS_LO;
        if (sim_pos > POS_HI) sim_pos = POS_HI;
        it.now = sim_now;
        it.pos = sim_pos[23:0];
        tick_q.push_back(it);
        cmd_q.push_back(predict_tick(it));
    endtask

    task automatic reg_write(bit [2:0] idx, bit [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CALIB_TIMEOUT: r_timeout = val[15:0];
            REG_POS_DEADBAND:  r_db = val[9:0];
            REG_DRIVE_GAIN:    r_gain = val[15:0];
            REG_MIN_SPEED:     r_min = val[15:0];
            REG_MAX_SPEED:     r_max = val[15:0];
            REG_BACKOFF:       r_backoff = val[15:0];
            REG_MANUAL_MOVE:   r_manual = val[9:0];
            default:           r_fdb = val[14:0];
        endcase
    endtask

    task automatic drain();
        while (tick_q.size() != 0 || cmd_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (tick_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (!quiet && $urandom % 6 == 0) begin
                src_gap <= $urandom_range(0, 9);
                s_axis_tvalid <= 1'b0;
            end else begin
                drv_tick = tick_q.pop_front();
                s_axis_tdata <= {2'b00, drv_tick.tv, drv_tick.tn, drv_tick.rc, drv_tick.cp,
                                 drv_tick.pos, drv_tick.ccw, drv_tick.cw, drv_tick.pg,
                                 drv_tick.now};
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (cmd_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time,
                             m_axis_tdata);
                    errors++;
                end else begin
                    got = cmd_q.pop_front();
                    check_field("ctrl_mode", got.mode, m_axis_tdata[2:0]);
                    check_field("coil_enable", got.coil, m_axis_tdata[3]);
                    check_field("motion", got.mot, m_axis_tdata[5:4]);
                    check_field("step_rate", got.rate, m_axis_tdata[21:6]);
                    check_field("sensor_zero", got.zero, m_axis_tdata[22]);
                    check_field("trim_send", got.send, m_axis_tdata[23]);
                    check_field("trim_out", got.trim, m_axis_tdata[39:24]);
                    check_field("led_mode", got.led, m_axis_tdata[41:40]);
                    check_field("zero fill", 0, m_axis_tdata[47:42]);
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom % 6 == 0) begin
                snk_gap <= $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        sim_now = 32'hffff_fff0 - $urandom_range(0, 200);
        sim_pos = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // defaults: power-up, calibration, then each follow operation
        plan_cw = -longint'($urandom_range(500, 3000));
        plan_ccw = $urandom_range(500, 3000);
        gen_tick(OP_NO_POWER);
        gen_tick(OP_NO_POWER);
        for (int i = 0; i < 60 && ctl_phase != PH_FOLLOW; i++) gen_tick(OP_AUTO);
        gen_tick(OP_TRIM_MAX);
        repeat (3) gen_tick(OP_AUTO);
        gen_tick(OP_TRIM_MIN);
        repeat (3) gen_tick(OP_AUTO);
        gen_tick(OP_CENTRE);
        repeat (3) gen_tick(OP_AUTO);
        gen_tick(OP_LIM_CW);
        repeat (2) gen_tick(OP_AUTO);
        gen_tick(OP_LIM_CCW);
        repeat (100) gen_tick(OP_AUTO);

        // reversed limits, random settings
        drain();
        reg_write(REG_CALIB_TIMEOUT, 65535);
        reg_write(REG_POS_DEADBAND, $urandom_range(0, 20));
        reg_write(REG_DRIVE_GAIN, $urandom_range(0, 65535));
        reg_write(REG_MIN_SPEED, $urandom_range(0, 1000));
        reg_write(REG_MAX_SPEED, $urandom_range(0, 65535));
        reg_write(REG_BACKOFF, $urandom_range(0, 65535));
        reg_write(REG_MANUAL_MOVE, $urandom_range(0, 1023));
        reg_write(REG_FOLLOW_DB, $urandom_range(0, 32767));
        plan_cw = $urandom_range(500, 5000);
        plan_ccw = -longint'($urandom_range(500, 5000));
        gen_tick(OP_RECAL);
        repeat (150) gen_tick(OP_AUTO);

        // full travel, tightest and fastest settings
        drain();
        reg_write(REG_POS_DEADBAND, 0);
        reg_write(REG_DRIVE_GAIN, 65535);
        reg_write(REG_MIN_SPEED, 0);
        reg_write(REG_MAX_SPEED, 65535);
        reg_write(REG_BACKOFF, 65535);
        reg_write(REG_MANUAL_MOVE, 0);
        reg_write(REG_FOLLOW_DB, 0);
        plan_cw = POS_LO;
        plan_ccw = POS_HI;
        gen_tick(OP_RECAL);
        repeat (130) gen_tick(OP_AUTO);

        // zero span, widest bands, clamps reversed
        drain();
        quiet <= 1'b1;
        reg_write(REG_POS_DEADBAND, 1023);
        reg_write(REG_DRIVE_GAIN, 0);
        reg_write(REG_MIN_SPEED, 65535);
        reg_write(REG_MAX_SPEED, 0);
        reg_write(REG_MANUAL_MOVE, 1023);
        reg_write(REG_FOLLOW_DB, 32767);
        plan_cw = 1234;
        plan_ccw = 1234;
        gen_tick(OP_RECAL);
        repeat (100) gen_tick(OP_AUTO);

        // no calibration time left: fault latches
        drain();
        reg_write(REG_CALIB_TIMEOUT, 0);
        gen_tick(OP_RECAL);
        repeat (15) gen_tick(OP_AUTO);

        while (tick_q.size() != 0 || cmd_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
